@@ src/per_cell_mean_accumulator_assert.svh @@
// Assertion macros for the per-cell mean accumulator.
// Included by the top level only; needs no package.
`ifndef PER_CELL_MEAN_ACCUMULATOR_ASSERT_SVH
`define PER_CELL_MEAN_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, held off while reset is low
`define PCMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low
`define PCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pcma_pkg.sv @@
// Shared types and constants for the per-cell mean accumulator.
// No dependencies; used by pcma_div and the top level.
package pcma_pkg;

    // Parameter defaults
    localparam int NUM_CELLS_DEF   = 4096;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 32;

    // Fixed port field widths
    localparam int OP_W        = 2;
    localparam int IDX_W       = 12;
    localparam int SAMPLE_W    = 32;
    localparam int MEAN_W      = 32;
    localparam int COUNT_OUT_W = 16;

    // Operation codes; the unused code behaves as a read
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_UPDATE = 7'b0001000,
        S_PREP   = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ src/pcma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcma_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/pcma_div.sv @@
// Radix-2 restoring divider: unsigned magnitude over count, 32-bit quotient,
// all ones when the quotient does not fit. Depends on pcma_pkg.
module pcma_div #(
    parameter int SUM_BITS   = pcma_pkg::SAMPLE_BITS_DEF + pcma_pkg::COUNT_BITS_DEF,
    parameter int COUNT_BITS = pcma_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [SUM_BITS-1:0]           i_dividend,
    input  logic [COUNT_BITS-1:0]         i_divisor,
    output pcma_pkg::t_div_stat           o_stat,
    output logic [pcma_pkg::MEAN_W-1:0]   o_quotient
);

    localparam int QW    = pcma_pkg::MEAN_W;
    localparam int EXT_W = SUM_BITS + QW;
    localparam int STEPW = $clog2(QW);

    logic [EXT_W-1:0]      w_ext;
    logic [SUM_BITS-1:0]   w_hi;
    logic [COUNT_BITS:0]   w_rem2;
    logic                  w_ge;
    logic [COUNT_BITS:0]   w_diff;

    logic                  r_busy;
    logic                  r_done;
    logic [STEPW-1:0]      r_step;
    logic [COUNT_BITS-1:0] r_div;
    logic [COUNT_BITS-1:0] r_rem;
    logic [QW-1:0]         r_lo;
    logic [QW-1:0]         r_quo;

    // Split dividend: upper part below divisor means quotient fits 32 bits
    assign w_ext = EXT_W'(i_dividend);
    assign w_hi  = w_ext[EXT_W-1:QW];

    // One quotient bit per cycle
    assign w_rem2 = {r_rem, r_lo[QW-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_div});
    assign w_diff = w_rem2 - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= '0;
                if (w_hi >= SUM_BITS'(i_divisor)) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEPW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= w_hi[COUNT_BITS-1:0];
            r_lo  <= w_ext[QW-1:0];
            r_quo <= '1;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_rem2[COUNT_BITS-1:0];
            r_lo  <= {r_lo[QW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

@@ src/per_cell_mean_accumulator.sv @@
// Per-cell mean accumulator: cell table RAM, sequencer, shared divider.
// Each item steps through read, update and prep, then a divide for a present cell (cut short
// when the quotient overflows), then finish; next input taken the cycle after the result loads.
// Rate set by the radix-2 divider (32 iterations) plus the RAM read-modify-write.
// Reset: synchronous, active low; then clears all NUM_CELLS cells, not ready meanwhile.
// Depends on pcma_pkg, pcma_ram, pcma_div and per_cell_mean_accumulator_assert.svh.
`include "per_cell_mean_accumulator_assert.svh"

module per_cell_mean_accumulator #(
    parameter int NUM_CELLS   = pcma_pkg::NUM_CELLS_DEF,
    parameter int COUNT_BITS  = pcma_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = pcma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [pcma_pkg::OP_W-1:0]          i_op,
    input  logic [pcma_pkg::IDX_W-1:0]         i_cell_req,
    input  logic signed [pcma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                               i_sample_present,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pcma_pkg::MEAN_W-1:0] o_mean,
    output logic                               o_mean_present,
    output logic [pcma_pkg::COUNT_OUT_W-1:0]   o_count_after,
    output logic                               o_count_saturated
);

    localparam int AW     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int SUMW   = SAMPLE_BITS + COUNT_BITS;
    localparam int WORD_W = 1 + COUNT_BITS + SUMW;
    localparam int QW     = pcma_pkg::MEAN_W;

    pcma_pkg::t_state r_state;

    logic [AW-1:0]                 r_clr;
    logic [pcma_pkg::OP_W-1:0]     r_op;
    logic [AW-1:0]                 r_addr;
    logic                          r_oob;
    logic [pcma_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_have;
    logic                          r_pres;
    logic [COUNT_BITS-1:0]         r_cnt;
    logic [SUMW-1:0]               r_sum;
    logic                          r_sat;
    logic                          r_neg;
    logic [SUMW-1:0]               r_mag;
    logic                          r_div_start;

    logic                          r_out_valid;
    logic [QW-1:0]                 r_mean;
    logic                          r_mean_present;
    logic [pcma_pkg::COUNT_OUT_W-1:0] r_count_after;
    logic                          r_count_sat;

    logic                          w_ram_we;
    logic [AW-1:0]                 w_ram_waddr;
    logic [WORD_W-1:0]             w_ram_wdata;
    logic [WORD_W-1:0]             w_ram_rdata;

    logic                          w_old_pres;
    logic [COUNT_BITS-1:0]         w_old_cnt;
    logic [SUMW-1:0]               w_old_sum;
    logic [SUMW-1:0]               w_smp;
    logic                          n_pres;
    logic [COUNT_BITS-1:0]         n_cnt;
    logic [SUMW-1:0]               n_sum;
    logic                          n_sat;

    pcma_pkg::t_div_stat           w_div_stat;
    logic [QW-1:0]                 w_quo;
    logic [QW-1:0]                 w_mean_fin;
    logic                          w_accept;
    logic                          w_load_out;

    // Sample is the low SAMPLE_BITS two's complement, or the field zero-extended if wider
    generate
        if (SAMPLE_BITS <= pcma_pkg::SAMPLE_W) begin : g_smp_narrow
            assign w_smp = SUMW'(signed'(r_sample[SAMPLE_BITS-1:0]));
        end else begin : g_smp_wide
            assign w_smp = SUMW'(r_sample);
        end
    endgenerate

    assign {w_old_pres, w_old_cnt, w_old_sum} = w_ram_rdata;

    // Cell update for the current item
    always_comb begin
        n_pres = w_old_pres;
        n_cnt  = w_old_cnt;
        n_sum  = w_old_sum;
        n_sat  = 1'b0;
        case (r_op)
            pcma_pkg::OP_ADD: begin
                if (r_have) begin
                    if (!w_old_pres) begin
                        n_pres = 1'b1;
                        n_cnt  = COUNT_BITS'(1);
                        n_sum  = w_smp;
                    end else if (w_old_cnt == '1) begin
                        n_sat = 1'b1;
                    end else begin
                        n_cnt = w_old_cnt + 1'b1;
                        n_sum = w_old_sum + w_smp;
                    end
                end
            end
            pcma_pkg::OP_REMOVE: begin
                if (r_have && w_old_pres) begin
                    if (w_old_cnt < COUNT_BITS'(2)) begin
                        n_pres = 1'b0;
                        n_cnt  = '0;
                        n_sum  = '0;
                    end else begin
                        n_cnt = w_old_cnt - 1'b1;
                        n_sum = w_old_sum - w_smp;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Table port: clearing pass, then write-back in the update step for an in-range cell
    assign w_ram_we    = (r_state == pcma_pkg::S_CLEAR) ||
                         ((r_state == pcma_pkg::S_UPDATE) && !r_oob);
    assign w_ram_waddr = (r_state == pcma_pkg::S_CLEAR) ? r_clr : r_addr;
    assign w_ram_wdata = (r_state == pcma_pkg::S_CLEAR) ? '0 : {n_pres, n_cnt, n_sum};

    pcma_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_CELLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    pcma_div #(
        .SUM_BITS   (SUMW),
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_cnt),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    // Sign and saturate the quotient; zero for a missing cell
    always_comb begin
        if (!r_pres) begin
            w_mean_fin = '0;
        end else if (r_neg) begin
            w_mean_fin = (w_quo > {1'b1, {(QW-1){1'b0}}}) ? {1'b1, {(QW-1){1'b0}}}
                                                         : (~w_quo + 1'b1);
        end else begin
            w_mean_fin = w_quo[QW-1] ? {1'b0, {(QW-1){1'b1}}} : w_quo;
        end
    end

    assign o_in_ready = (r_state == pcma_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == pcma_pkg::S_FIN) && (!r_out_valid || i_out_ready);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcma_pkg::S_CLEAR;
            r_clr       <= '0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                pcma_pkg::S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(NUM_CELLS - 1)) begin
                        r_state <= pcma_pkg::S_IDLE;
                    end
                end
                pcma_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_state <= pcma_pkg::S_READ;
                    end
                end
                pcma_pkg::S_READ: begin
                    r_state <= pcma_pkg::S_UPDATE;
                end
                pcma_pkg::S_UPDATE: begin
                    r_state <= pcma_pkg::S_PREP;
                end
                pcma_pkg::S_PREP: begin
                    if (r_pres) begin
                        r_div_start <= 1'b1;
                        r_state     <= pcma_pkg::S_DIV;
                    end else begin
                        r_state <= pcma_pkg::S_FIN;
                    end
                end
                pcma_pkg::S_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= pcma_pkg::S_FIN;
                    end
                end
                pcma_pkg::S_FIN: begin
                    if (w_load_out) begin
                        r_state <= pcma_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= pcma_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Item capture and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_addr   <= AW'(i_cell_req);
            r_oob    <= (32'(i_cell_req) >= 32'(NUM_CELLS));
            r_sample <= i_sample;
            r_have   <= i_sample_present;
        end
        if (r_state == pcma_pkg::S_UPDATE) begin
            r_pres <= !r_oob && n_pres && (n_cnt != '0);
            r_cnt  <= n_cnt;
            r_sum  <= n_sum;
            r_sat  <= !r_oob && n_sat;
        end
        if (r_state == pcma_pkg::S_PREP) begin
            r_neg <= r_sum[SUMW-1];
            r_mag <= r_sum[SUMW-1] ? (~r_sum + 1'b1) : r_sum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_mean         <= w_mean_fin;
            r_mean_present <= r_pres;
            r_count_after  <= r_pres ? pcma_pkg::COUNT_OUT_W'(r_cnt) : '0;
            r_count_sat    <= r_sat;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_mean            = r_mean;
    assign o_mean_present    = r_mean_present;
    assign o_count_after     = r_count_after;
    assign o_count_saturated = r_count_sat;

    // Checks
    `PCMA_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, w_div_stat.done, r_state == pcma_pkg::S_DIV, "divider finished outside the divide step")
    `PCMA_ASSERT_NOW(a_missing_zero, i_clk, i_rst_n, o_out_valid && !o_mean_present, (o_mean == '0) && (o_count_after == '0), "missing cell result carries nonzero fields")
    `PCMA_ASSERT_NEXT(a_start_from_prep, i_clk, i_rst_n, r_div_start, w_div_stat.busy || w_div_stat.done, "divider ignored a start")

endmodule
